[hw/rtl/assert_macros.svh]
// Assertion macros used by the RTL of the interrupt routing block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk_i outside reset.
`define IRTD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge of clk_i outside reset.
`define IRTD_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[hw/rtl/irtd_pkg.sv]
// Types and codes shared by the interrupt routing table modules.
`default_nettype none

package irtd_pkg;

  // Request operations
  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_ENABLE   = 2'd1;
  localparam logic [1:0] OP_EVENT    = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_STATUS   = 2'd0;
  localparam logic [1:0] KIND_TIMER    = 2'd1;
  localparam logic [1:0] KIND_DISPATCH = 2'd2;
  localparam logic [1:0] KIND_SPURIOUS = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_OWNER = 2'd2;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned WORDS_W = 3 * WORD_W;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  core;
    logic [7:0]  irq;
    logic [7:0]  owner;
    logic [63:0] v0_word;
    logic [63:0] arg_word;
    logic [63:0] cap_handle;
    logic [31:0] pending;
    logic        timer_pending;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [7:0]  target;
    logic [4:0]  line;
    logic [63:0] out_v0;
    logic [63:0] out_arg;
    logic [63:0] out_cap;
    logic        last;
  } res_t;

  typedef struct packed {
    logic hit;
    logic empty;
  } scan_stat_t;

  function automatic res_t make_simple(logic [1:0] kind, logic [1:0] status, logic last);
    res_t r;
    r        = '0;
    r.kind   = kind;
    r.status = status;
    r.last   = last;
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/irtd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module irtd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  wire                                     clk_i,
  input  wire                                     we_i,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]                        wdata_i,
  input  wire                                     re_i,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/irtd_scan.sv]
// Bit-serial scan unit: walks a work vector one line per step, lowest first.
`default_nettype none

module irtd_scan
  import irtd_pkg::*;
#(
  parameter int unsigned NUM_IRQS = 32
) (
  input  wire                                           clk_i,
  input  wire                                           rst_ni,
  input  wire                                           load_i,
  input  wire  [NUM_IRQS-1:0]                           work_i,
  input  wire                                           step_i,
  output logic [(NUM_IRQS > 1 ? $clog2(NUM_IRQS) : 1)-1:0] idx_o,
  output scan_stat_t                                    stat_o
);

  localparam int unsigned IRQ_W = NUM_IRQS > 1 ? $clog2(NUM_IRQS) : 1;

  logic [NUM_IRQS-1:0] work_q, work_d;
  logic [IRQ_W-1:0]    idx_q, idx_d;

  always_comb begin
    work_d = work_q;
    idx_d  = idx_q;
    if (load_i) begin
      work_d = work_i;
      idx_d  = '0;
    end else if (step_i) begin
      // drop the current line and advance
      work_d[idx_q] = 1'b0;
      idx_d         = idx_q + IRQ_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q <= '0;
      idx_q  <= '0;
    end else begin
      work_q <= work_d;
      idx_q  <= idx_d;
    end
  end

  assign idx_o        = idx_q;
  assign stat_o.hit   = work_q[idx_q];
  assign stat_o.empty = (work_q == '0);

endmodule

`default_nettype wire

[hw/rtl/interrupt_route_table_dispatch.sv]
// Register/enable rejected at once reply in the cycle after start; others pass through S_CHECK.
// Event: timer or spurious result in the cycle after start; then the bit-serial scan unit
// checks one line per cycle in S_SCAN, pausing in S_EMIT for the table read of each dispatch.
// Results cannot be stalled. After reset, busy stays high while all NUM_CORES*NUM_IRQS
// entries of the owner table are cleared, one entry per cycle.
`default_nettype none
`include "assert_macros.svh"

module interrupt_route_table_dispatch
  import irtd_pkg::*;
#(
  parameter int unsigned NUM_IRQS  = 32,
  parameter int unsigned NUM_CORES = 4
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   start,
  output logic  busy,
  input  wire req_t req_i,
  output logic  res_valid_o,
  output res_t  res_o
);

  localparam int unsigned IRQ_W   = NUM_IRQS > 1 ? $clog2(NUM_IRQS) : 1;
  localparam int unsigned CORE_W  = NUM_CORES > 1 ? $clog2(NUM_CORES) : 1;
  localparam int unsigned ENTRIES = NUM_CORES * NUM_IRQS;
  localparam int unsigned ADDR_W  = ENTRIES > 1 ? $clog2(ENTRIES) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [ADDR_W-1:0]   clr_cnt_q, clr_cnt_d;
  logic [NUM_IRQS-1:0] mask_q [NUM_CORES];
  logic [NUM_IRQS-1:0] mask_d [NUM_CORES];
  req_t                item_q, item_d;
  res_t                res_q, res_d;
  logic                res_valid_q, res_valid_d;

  logic                accept;
  logic                core_ok, irq_ok;
  logic [CORE_W-1:0]   in_core, item_core;
  logic [IRQ_W-1:0]    in_line, item_line, scan_idx;
  logic [ADDR_W-1:0]   in_addr, item_addr, scan_addr;
  logic [NUM_IRQS-1:0] work_in;
  scan_stat_t          scan_stat;
  logic                scan_load, scan_step;

  logic                own_we, own_re, words_we, words_re;
  logic [ADDR_W-1:0]   own_waddr, rd_addr;
  logic [7:0]          own_wdata, own_rdata;
  logic [WORDS_W-1:0]  words_rdata;
  logic                reg_ok, en_ok;

  assign accept  = start && !busy;
  assign busy    = (state_q != S_IDLE);
  assign core_ok = (32'(req_i.core) < NUM_CORES);
  assign irq_ok  = (32'(req_i.irq) < NUM_IRQS);

  assign in_core   = CORE_W'(req_i.core);
  assign in_line   = IRQ_W'(req_i.irq);
  assign item_core = CORE_W'(item_q.core);
  assign item_line = IRQ_W'(item_q.irq);

  assign in_addr   = ADDR_W'(ADDR_W'(in_core) * ADDR_W'(NUM_IRQS) + ADDR_W'(in_line));
  assign item_addr = ADDR_W'(ADDR_W'(item_core) * ADDR_W'(NUM_IRQS) + ADDR_W'(item_line));
  assign scan_addr = ADDR_W'(ADDR_W'(item_core) * ADDR_W'(NUM_IRQS) + ADDR_W'(scan_idx));

  assign work_in = core_ok ? (mask_q[in_core] & req_i.pending[NUM_IRQS-1:0]) : '0;

  assign scan_load = accept && (req_i.op == OP_EVENT);
  assign scan_step = (state_q == S_SCAN);

  irtd_scan #(
    .NUM_IRQS(NUM_IRQS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (scan_load),
    .work_i (work_in),
    .step_i (scan_step),
    .idx_o  (scan_idx),
    .stat_o (scan_stat)
  );

  assign reg_ok = (own_rdata == 8'd0) || (own_rdata == item_q.owner);
  assign en_ok  = (own_rdata == item_q.owner);

  // Owner table: cleared after reset, written on accepted registration
  assign own_we    = (state_q == S_CLEAR) ||
                     ((state_q == S_CHECK) && (item_q.op == OP_REGISTER) && reg_ok);
  assign own_waddr = (state_q == S_CLEAR) ? clr_cnt_q : item_addr;
  assign own_wdata = (state_q == S_CLEAR) ? 8'd0 : item_q.owner;
  assign own_re    = (accept && ((req_i.op == OP_REGISTER) || (req_i.op == OP_ENABLE))) ||
                     ((state_q == S_SCAN) && scan_stat.hit);
  assign rd_addr   = (state_q == S_IDLE) ? in_addr : scan_addr;

  assign words_we = (state_q == S_CHECK) && (item_q.op == OP_REGISTER) && reg_ok;
  assign words_re = (state_q == S_SCAN) && scan_stat.hit;

  irtd_ram #(
    .WIDTH(8),
    .DEPTH(ENTRIES)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (own_waddr),
    .wdata_i (own_wdata),
    .re_i    (own_re),
    .raddr_i (rd_addr),
    .rdata_o (own_rdata)
  );

  irtd_ram #(
    .WIDTH(WORDS_W),
    .DEPTH(ENTRIES)
  ) u_words_ram (
    .clk_i   (clk_i),
    .we_i    (words_we),
    .waddr_i (item_addr),
    .wdata_i ({item_q.v0_word, item_q.arg_word, item_q.cap_handle}),
    .re_i    (words_re),
    .raddr_i (rd_addr),
    .rdata_o (words_rdata)
  );

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    item_d      = item_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    mask_d      = mask_q;

    unique case (state_q)
      S_CLEAR: begin
        clr_cnt_d = clr_cnt_q + ADDR_W'(1);
        if (clr_cnt_q == ADDR_W'(ENTRIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          item_d = req_i;
          unique case (req_i.op) inside
            OP_REGISTER, OP_ENABLE: begin
              if (!irq_ok || !core_ok) begin
                res_d       = make_simple(KIND_STATUS, ST_RANGE, 1'b1);
                res_valid_d = 1'b1;
              end else if (req_i.owner == 8'd0) begin
                res_d       = make_simple(KIND_STATUS, ST_OWNER, 1'b1);
                res_valid_d = 1'b1;
              end else begin
                state_d = S_CHECK;
              end
            end
            OP_EVENT: begin
              if (req_i.timer_pending) begin
                res_d       = make_simple(KIND_TIMER, ST_OK, work_in == '0);
                res_valid_d = 1'b1;
              end else if (work_in == '0) begin
                res_d       = make_simple(KIND_SPURIOUS, ST_OK, 1'b1);
                res_valid_d = 1'b1;
              end
              if (work_in != '0) begin
                state_d = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
        if (item_q.op == OP_REGISTER) begin
          res_d = make_simple(KIND_STATUS, reg_ok ? ST_OK : ST_OWNER, 1'b1);
        end else begin
          res_d = make_simple(KIND_STATUS, en_ok ? ST_OK : ST_OWNER, 1'b1);
          if (en_ok) begin
            mask_d[item_core][item_line] = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (scan_stat.hit) begin
          // one-shot: disarm the line as it is dispatched
          mask_d[item_core][scan_idx] = 1'b0;
          res_d.line = 5'(scan_idx);
          state_d    = S_EMIT;
        end
      end
      S_EMIT: begin
        res_d.kind    = KIND_DISPATCH;
        res_d.status  = ST_OK;
        res_d.target  = own_rdata;
        res_d.out_v0  = words_rdata[3*WORD_W-1:2*WORD_W];
        res_d.out_arg = words_rdata[2*WORD_W-1:WORD_W];
        res_d.out_cap = words_rdata[WORD_W-1:0];
        res_d.last    = scan_stat.empty;
        res_valid_d   = 1'b1;
        state_d       = scan_stat.empty ? S_IDLE : S_SCAN;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      res_valid_q <= 1'b0;
      for (int c = 0; c < NUM_CORES; c++) begin
        mask_q[c] <= '0;
      end
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      res_valid_q <= res_valid_d;
      mask_q      <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `IRTD_NEVER(a_no_result_in_clear, (state_q == S_CLEAR) && res_valid_q,
              "result issued during owner table clear")
  `IRTD_ASSERT(a_quiet_after_last,
               (res_valid_o && res_o.last && !(start && !busy)) |=> !res_valid_o,
               "result issued after last without a new item")
  `IRTD_ASSERT(a_dispatch_owned,
               (res_valid_o && (res_o.kind == KIND_DISPATCH)) |-> (res_o.target != 8'd0),
               "dispatch of an unowned line")

endmodule

`default_nettype wire

[tb/irtd_dispatch_checker.sv]
// Checker for the interrupt routing table: predicts results per item and compares them.
`timescale 1ns / 100ps

module irtd_dispatch_checker
  import irtd_pkg::*;
#(
  parameter int unsigned NUM_IRQS  = 32,
  parameter int unsigned NUM_CORES = 4
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  input  wire               busy_i,
  input  req_t              req_i,
  input  wire               res_valid_i,
  input  res_t              res_i,
  output int unsigned       outstanding_o,
  output int unsigned       err_cnt_o
);

  logic [7:0]  line_owner [NUM_CORES*NUM_IRQS];
  logic [63:0] line_v0    [NUM_CORES*NUM_IRQS];
  logic [63:0] line_arg   [NUM_CORES*NUM_IRQS];
  logic [63:0] line_cap   [NUM_CORES*NUM_IRQS];
  logic [31:0] armed_mask [NUM_CORES];

  res_t due_results[$];

  task automatic cmp_field(input string name, input logic [63:0] want,
                           input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      err_cnt_o++;
    end
  endtask

  // Append the results one accepted item causes and update the table state.
  task automatic route_item(input req_t item);
    int unsigned idx;
    int unsigned first;
    logic [1:0]  st;
    logic [31:0] work;
    res_t        r;
    if (item.op == OP_REGISTER || item.op == OP_ENABLE) begin
      if (item.irq >= NUM_IRQS || item.core >= NUM_CORES) begin
        st = ST_RANGE;
      end else begin
        idx = item.core * NUM_IRQS + item.irq;
        if (item.owner == 8'd0) begin
          st = ST_OWNER;
        end else if (item.op == OP_REGISTER) begin
          if (line_owner[idx] != 8'd0 && line_owner[idx] != item.owner) begin
            st = ST_OWNER;
          end else begin
            line_owner[idx] = item.owner;
            line_v0[idx]    = item.v0_word;
            line_arg[idx]   = item.arg_word;
            line_cap[idx]   = item.cap_handle;
            st = ST_OK;
          end
        end else if (line_owner[idx] != item.owner) begin
          st = ST_OWNER;
        end else begin
          armed_mask[item.core][item.irq[4:0]] = 1'b1;
          st = ST_OK;
        end
      end
      r        = '0;
      r.kind   = KIND_STATUS;
      r.status = st;
      r.last   = 1'b1;
      due_results.push_back(r);
    end else if (item.op == OP_EVENT) begin
      first = due_results.size();
      work  = (item.core < NUM_CORES) ? (item.pending & armed_mask[item.core]) : '0;
      if (item.timer_pending) begin
        r      = '0;
        r.kind = KIND_TIMER;
        due_results.push_back(r);
      end
      for (int i = 0; i < NUM_IRQS; i++) begin
        idx = item.core * NUM_IRQS + i;
        if (work[i] && line_owner[idx] != 8'd0) begin
          // one-shot: drop the enable bit of each dispatched line
          armed_mask[item.core][i] = 1'b0;
          r         = '0;
          r.kind    = KIND_DISPATCH;
          r.target  = line_owner[idx];
          r.line    = i[4:0];
          r.out_v0  = line_v0[idx];
          r.out_arg = line_arg[idx];
          r.out_cap = line_cap[idx];
          due_results.push_back(r);
        end
      end
      if (due_results.size() == first) begin
        r      = '0;
        r.kind = KIND_SPURIOUS;
        due_results.push_back(r);
      end
      r      = due_results.pop_back();
      r.last = 1'b1;
      due_results.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CORES * NUM_IRQS; i++) begin
        line_owner[i] = '0;
        line_v0[i]    = '0;
        line_arg[i]   = '0;
        line_cap[i]   = '0;
      end
      for (int c = 0; c < NUM_CORES; c++) armed_mask[c] = '0;
      due_results.delete();
      err_cnt_o     = 0;
      outstanding_o = 0;
    end else begin
      // compare before predicting: a new item's results never come on its own edge
      if (res_valid_i) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %h", $time, res_i);
          err_cnt_o++;
        end else begin
          want = due_results.pop_front();
          cmp_field("kind",    64'(want.kind),   64'(res_i.kind));
          cmp_field("status",  64'(want.status), 64'(res_i.status));
          cmp_field("target",  64'(want.target), 64'(res_i.target));
          cmp_field("line",    64'(want.line),   64'(res_i.line));
          cmp_field("out_v0",  want.out_v0,      res_i.out_v0);
          cmp_field("out_arg", want.out_arg,     res_i.out_arg);
          cmp_field("out_cap", want.out_cap,     res_i.out_cap);
          cmp_field("last",    64'(want.last),   64'(res_i.last));
        end
      end
      if (start_i && !busy_i) route_item(req_i);
      outstanding_o = due_results.size();
    end
  end

endmodule

[tb/interrupt_route_table_dispatch_test.sv]
// Testbench top for the interrupt routing table: drives requests and reports the verdict.
`timescale 1ns / 100ps

module interrupt_route_table_dispatch_test;
  import irtd_pkg::*;

  localparam int unsigned NUM_IRQS  = 32;
  localparam int unsigned NUM_CORES = 4;
  localparam int unsigned N_RANDOM  = 450;
  localparam int unsigned SETTLE    = 2 * NUM_IRQS + 8;

  // operation code the block does not define
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  req_t        req;
  logic        res_valid;
  res_t        res;
  int unsigned outstanding;
  int unsigned err_cnt;

  // stimulus hint only: which owner most likely holds each line
  logic [7:0]  owner_hint [NUM_CORES*NUM_IRQS];
  int unsigned burst_left;
  int unsigned n_sent;

  interrupt_route_table_dispatch #(
    .NUM_IRQS (NUM_IRQS),
    .NUM_CORES(NUM_CORES)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  irtd_dispatch_checker #(
    .NUM_IRQS (NUM_IRQS),
    .NUM_CORES(NUM_CORES)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .outstanding_o(outstanding),
    .err_cnt_o    (err_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t make_req(logic [1:0] op, logic [1:0] core, logic [7:0] irq,
                                    logic [7:0] owner, logic [31:0] pend, logic timer);
    req_t r;
    r.op            = op;
    r.core          = core;
    r.irq           = irq;
    r.owner         = owner;
    r.v0_word       = rand_word();
    r.arg_word      = rand_word();
    r.cap_handle    = rand_word();
    r.pending       = pend;
    r.timer_pending = timer;
    return r;
  endfunction

  // Hold the item on the bus until the block takes it.
  task automatic issue(input req_t item);
    @(negedge clk);
    start = 1'b1;
    req   = item;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (item.op == OP_REGISTER && item.irq < NUM_IRQS && item.owner != 8'd0 &&
        owner_hint[item.core*NUM_IRQS + item.irq] == 8'd0)
      owner_hint[item.core*NUM_IRQS + item.irq] = item.owner;
  endtask

  task automatic idle(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  // Stop sending until every expected result has come, then let the block settle.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_owner(logic [1:0] core, logic [7:0] irq);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'd0;
    if (roll == 1 || irq >= NUM_IRQS) return 8'($urandom);
    if (owner_hint[core*NUM_IRQS + irq] != 8'd0) return owner_hint[core*NUM_IRQS + irq];
    return 8'($urandom_range(1, 4));
  endfunction

  initial begin
    req_t        item;
    logic [1:0]  core;
    logic [7:0]  irq;
    logic [31:0] pend;
    int unsigned roll;

    start = 1'b0;
    req   = '0;
    rst_n = 1'b0;
    for (int i = 0; i < NUM_CORES * NUM_IRQS; i++) owner_hint[i] = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, refusals, one-shot dispatch, timer, spurious, unknown op
    item = make_req(OP_REGISTER, 2'd0, 8'd0, 8'd1, '0, 1'b0);
    item.v0_word = '1;  item.arg_word = '1;  item.cap_handle = '1;
    issue(item);
    item = make_req(OP_REGISTER, 2'd0, 8'd31, 8'd255, '0, 1'b0);
    item.v0_word = '0;  item.arg_word = '0;  item.cap_handle = '0;
    issue(item);
    issue(make_req(OP_REGISTER, 2'd3, 8'd32, 8'd5, '0, 1'b0));
    issue(make_req(OP_REGISTER, 2'd1, 8'd255, 8'd5, '1, 1'b1));
    issue(make_req(OP_REGISTER, 2'd2, 8'd5, 8'd0, '0, 1'b0));
    issue(make_req(OP_REGISTER, 2'd0, 8'd0, 8'd2, '0, 1'b0));
    issue(make_req(OP_REGISTER, 2'd0, 8'd0, 8'd1, '0, 1'b0));
    issue(make_req(OP_ENABLE, 2'd0, 8'd0, 8'd2, '0, 1'b0));
    issue(make_req(OP_ENABLE, 2'd0, 8'd0, 8'd0, '0, 1'b0));
    issue(make_req(OP_ENABLE, 2'd0, 8'd200, 8'd1, '0, 1'b0));
    issue(make_req(OP_ENABLE, 2'd0, 8'd3, 8'd7, '0, 1'b0));
    issue(make_req(OP_ENABLE, 2'd0, 8'd0, 8'd1, '0, 1'b0));
    issue(make_req(OP_ENABLE, 2'd0, 8'd31, 8'd255, '0, 1'b0));
    issue(make_req(OP_EVENT, 2'd1, 8'd0, 8'd0, '0, 1'b0));
    issue(make_req(OP_EVENT, 2'd1, 8'd0, 8'd0, '1, 1'b1));
    issue(make_req(OP_EVENT, 2'd0, 8'd0, 8'd0, '1, 1'b1));
    issue(make_req(OP_EVENT, 2'd0, 8'd0, 8'd0, '1, 1'b0));
    issue(make_req(OP_ENABLE, 2'd0, 8'd0, 8'd1, '0, 1'b0));
    issue(make_req(OP_EVENT, 2'd0, 8'd0, 8'd0, 32'hFFFF_FFFE, 1'b0));
    issue(make_req(OP_EVENT, 2'd0, 8'd0, 8'd0, 32'h0000_0001, 1'b1));
    item = make_req(OP_UNKNOWN, 2'd3, 8'hFF, 8'hFF, '1, 1'b1);
    issue(item);
    issue(make_req(OP_EVENT, 2'd3, 8'd0, 8'd0, '0, 1'b1));
    drain();

    n_sent     = 0;
    burst_left = 0;
    while (n_sent < N_RANDOM) begin
      if (burst_left == 0) begin
        idle($urandom_range(1, 8));
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 8);
      end
      burst_left--;
      core = 2'($urandom_range(0, NUM_CORES - 1));
      irq  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(32, 255))
                                         : 8'($urandom_range(0, NUM_IRQS - 1));
      case ($urandom_range(0, 9))
        0:          pend = '0;
        1, 2, 3, 4: pend = '1;
        5, 6, 7:    pend = $urandom;
        default:    pend = $urandom & $urandom & $urandom;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        issue(make_req(OP_REGISTER, core, irq, pick_owner(core, irq), $urandom,
                       1'($urandom)));
      end else if (roll < 70) begin
        issue(make_req(OP_ENABLE, core, irq, pick_owner(core, irq), $urandom,
                       1'($urandom)));
      end else if (roll < 95) begin
        issue(make_req(OP_EVENT, core, 8'($urandom), 8'($urandom), pend,
                       1'($urandom_range(0, 1))));
      end else begin
        // unknown op: ignored by the block, not counted
        issue(make_req(OP_UNKNOWN, core, 8'($urandom), 8'($urandom), pend, 1'($urandom)));
        continue;
      end
      n_sent++;
      if (n_sent % 150 == 0) drain();
    end

    drain();
    if (err_cnt == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/irtd_pkg.sv
hw/rtl/irtd_ram.sv
hw/rtl/irtd_scan.sv
hw/rtl/interrupt_route_table_dispatch.sv
tb/irtd_dispatch_checker.sv
tb/interrupt_route_table_dispatch_test.sv
